// ----- hdl/hdc_pkg.sv -----
// ----------------------------------------------------------------------------
// hdc_pkg: shared types and constants of the hex dihedral cosine block
// Item structs, sequencer states and the edge-to-face template.
// ----------------------------------------------------------------------------
package hdc_pkg;

  localparam int CosFracBits = 16;
  localparam int CosBits     = CosFracBits + 1;
  localparam int NumEdges    = 12;
  localparam int NumVerts    = 8;
  localparam int EdgeBits    = 4;

  typedef struct packed {
    logic signed [15:0] coord_x;
    logic signed [15:0] coord_y;
    logic signed [15:0] coord_z;
  } in_item_t;

  typedef struct packed {
    logic [EdgeBits-1:0] edge_index;
    logic [CosBits-1:0]  cosine;
    logic                degenerate;
    logic                last_edge;
  } out_item_t;

  typedef enum logic [3:0] {
    SeqCollect,
    SeqLoadP0,
    SeqLoadP1,
    SeqLoadP2,
    SeqCross,
    SeqDot,
    SeqCheck,
    SeqSquare,
    SeqDivide,
    SeqRoot,
    SeqEmit
  } seq_e;

  // First three vertices {v0, v1, v2} of one face adjoining an edge.
  function automatic logic [8:0] edge_face_tri(input logic [EdgeBits-1:0] edge_idx,
                                               input logic face);
    logic [8:0] tri_v;
    unique case ({edge_idx, face})
      {4'd0,  1'b0}: tri_v = {3'd1, 3'd0, 3'd4};
      {4'd0,  1'b1}: tri_v = {3'd0, 3'd1, 3'd2};
      {4'd1,  1'b0}: tri_v = {3'd2, 3'd1, 3'd5};
      {4'd1,  1'b1}: tri_v = {3'd1, 3'd2, 3'd3};
      {4'd2,  1'b0}: tri_v = {3'd3, 3'd2, 3'd6};
      {4'd2,  1'b1}: tri_v = {3'd2, 3'd3, 3'd0};
      {4'd3,  1'b0}: tri_v = {3'd0, 3'd3, 3'd7};
      {4'd3,  1'b1}: tri_v = {3'd3, 3'd0, 3'd1};
      {4'd4,  1'b0}: tri_v = {3'd5, 3'd4, 3'd7};
      {4'd4,  1'b1}: tri_v = {3'd4, 3'd5, 3'd1};
      {4'd5,  1'b0}: tri_v = {3'd6, 3'd5, 3'd4};
      {4'd5,  1'b1}: tri_v = {3'd5, 3'd6, 3'd2};
      {4'd6,  1'b0}: tri_v = {3'd7, 3'd6, 3'd5};
      {4'd6,  1'b1}: tri_v = {3'd6, 3'd7, 3'd3};
      {4'd7,  1'b0}: tri_v = {3'd4, 3'd7, 3'd6};
      {4'd7,  1'b1}: tri_v = {3'd7, 3'd4, 3'd0};
      {4'd8,  1'b0}: tri_v = {3'd0, 3'd4, 3'd5};
      {4'd8,  1'b1}: tri_v = {3'd0, 3'd3, 3'd7};
      {4'd9,  1'b0}: tri_v = {3'd1, 3'd5, 3'd6};
      {4'd9,  1'b1}: tri_v = {3'd1, 3'd0, 3'd4};
      {4'd10, 1'b0}: tri_v = {3'd2, 3'd6, 3'd7};
      {4'd10, 1'b1}: tri_v = {3'd2, 3'd1, 3'd5};
      {4'd11, 1'b0}: tri_v = {3'd3, 3'd7, 3'd4};
      {4'd11, 1'b1}: tri_v = {3'd3, 3'd2, 3'd6};
      default:       tri_v = '0;
    endcase
    return tri_v;
  endfunction

endpackage

// ----- hdl/hex_dihedral_cosines.sv -----
// ----------------------------------------------------------------------------
// hex_dihedral_cosines: absolute cosines of the twelve dihedral angles of a hex
// Collects eight vertices, then gives one cosine item per edge in edge order.
// ----------------------------------------------------------------------------
// Usage: drive one vertex per item on in_i with start high; an item is taken
// at an edge where start is high and busy is low. Vertices one to seven are
// taken back to back while busy stays low. After the eighth vertex, busy
// rises and the block works through edges 0..11; each result is on res_o for
// exactly one cycle, marked by res_strobe_o, and cannot be stalled. Every
// product goes through one shared 8-bit-digit multiply-accumulate unit with a
// wide adder, which also serves the restoring division; a narrow squarer
// serves the bit-wise square root. Each edge takes two normals of 6 products
// each, 9 dot-product terms and 2 wide products, each product worked digit by
// digit, then 33 division steps and 17 root steps; a face normal of zero
// length skips the wide products, division and root. A degenerate edge gives
// cosine 0 with the degenerate flag set; last_edge marks edge 11.
// Coordinates use the low COORD_BITS bits of each field as two's complement.
module hex_dihedral_cosines #(
  parameter int COORD_BITS = 16
) (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              start,
  output logic              busy,
  input  hdc_pkg::in_item_t in_i,
  output logic              res_strobe_o,
  output hdc_pkg::out_item_t res_o
);
  import hdc_pkg::*;

  // Datapath widths: difference, normal, dot product, wide product, accumulator.
  localparam int CB   = COORD_BITS;
  localparam int DB   = CB + 1;
  localparam int NB   = 2 * DB + 1;
  localparam int LB   = 2 * NB + 2;
  localparam int PW   = 2 * LB;
  localparam int W    = PW + 2;
  localparam int ND   = (LB + 7) / 8;
  localparam int NDC  = (DB + 7) / 8;
  localparam int NDD  = (NB + 7) / 8;
  localparam int DigW = $clog2(ND);
  localparam int QW   = 2 * CosFracBits + 1;
  localparam int BW   = $clog2(QW);

  localparam logic [DigW-1:0] CrossDigLast  = DigW'(NDC - 1);
  localparam logic [DigW-1:0] DotDigLast    = DigW'(NDD - 1);
  localparam logic [DigW-1:0] SquareDigLast = DigW'(ND - 1);
  localparam logic [3:0]      CrossTermLast  = 4'd5;
  localparam logic [3:0]      DotTermLast    = 4'd8;
  localparam logic [3:0]      SquareTermLast = 4'd1;
  localparam logic [EdgeBits-1:0] EdgeLast   = EdgeBits'(NumEdges - 1);

  seq_e st_q, st_d;
  logic [2:0]          vcnt_q;
  logic [EdgeBits-1:0] edge_q;
  logic                face_q;
  logic [3:0]          term_q;
  logic [DigW-1:0]     dig_q;
  logic [BW-1:0]       bit_q;

  logic signed [CB-1:0] vert_q [NumVerts][3];
  logic signed [CB-1:0] p0_q [3];
  logic signed [DB-1:0] a_q [3];
  logic signed [DB-1:0] b_q [3];
  logic signed [NB-1:0] n0_q [3];
  logic signed [NB-1:0] n1_q [3];
  logic signed [LB-1:0] dp_q, l0_q, l1_q;
  logic [PW-1:0]        prd_q;
  logic [W-1:0]         acc_q;
  logic [QW-1:0]        dq_q;
  logic [CosBits-1:0]   q_q;
  logic                 degen_q;

  // Vertex fetch from the template.
  logic [8:0] tri_v;
  logic [2:0] vidx;
  always_comb begin
    tri_v = edge_face_tri(edge_q, face_q);
    unique case (st_q)
      SeqLoadP0: vidx = tri_v[8:6];
      SeqLoadP1: vidx = tri_v[5:3];
      default:   vidx = tri_v[2:0];
    endcase
  end

  // Operand select for the shared multiply-accumulate unit.
  logic signed [LB-1:0] opa, opb;
  logic                 msub;
  always_comb begin
    opa  = '0;
    opb  = '0;
    msub = 1'b0;
    unique case (st_q)
      SeqCross: begin
        unique case (term_q)
          4'd0:    begin opa = LB'(a_q[1]); opb = LB'(b_q[2]); end
          4'd1:    begin opa = LB'(a_q[2]); opb = LB'(b_q[1]); msub = 1'b1; end
          4'd2:    begin opa = LB'(a_q[2]); opb = LB'(b_q[0]); end
          4'd3:    begin opa = LB'(a_q[0]); opb = LB'(b_q[2]); msub = 1'b1; end
          4'd4:    begin opa = LB'(a_q[0]); opb = LB'(b_q[1]); end
          4'd5:    begin opa = LB'(a_q[1]); opb = LB'(b_q[0]); msub = 1'b1; end
          default: begin opa = '0; opb = '0; end
        endcase
      end
      SeqDot: begin
        unique case (term_q)
          4'd0:    begin opa = LB'(n0_q[0]); opb = LB'(n1_q[0]); end
          4'd1:    begin opa = LB'(n0_q[1]); opb = LB'(n1_q[1]); end
          4'd2:    begin opa = LB'(n0_q[2]); opb = LB'(n1_q[2]); end
          4'd3:    begin opa = LB'(n0_q[0]); opb = LB'(n0_q[0]); end
          4'd4:    begin opa = LB'(n0_q[1]); opb = LB'(n0_q[1]); end
          4'd5:    begin opa = LB'(n0_q[2]); opb = LB'(n0_q[2]); end
          4'd6:    begin opa = LB'(n1_q[0]); opb = LB'(n1_q[0]); end
          4'd7:    begin opa = LB'(n1_q[1]); opb = LB'(n1_q[1]); end
          4'd8:    begin opa = LB'(n1_q[2]); opb = LB'(n1_q[2]); end
          default: begin opa = '0; opb = '0; end
        endcase
      end
      SeqSquare: begin
        if (term_q == 4'd0) begin
          opa = l0_q;
          opb = l1_q;
        end else begin
          opa = dp_q;
          opb = dp_q;
        end
      end
      default: begin
        opa = '0;
        opb = '0;
      end
    endcase
  end

  // Shared unit: magnitude times one 8-bit digit, shifted into one wide add.
  logic [LB-1:0]     amag, bmag;
  logic [ND*8-1:0]   bpad;
  logic [7:0]        digit;
  logic [LB+7:0]     pp;
  logic [W-1:0]      sh, addend, sum, rem_new;
  logic              neg, dsub, trial_ok;
  always_comb begin
    amag     = opa[LB-1] ? (~opa + 1'b1) : opa;
    bmag     = opb[LB-1] ? (~opb + 1'b1) : opb;
    bpad     = (ND*8)'(bmag);
    digit    = bpad[{dig_q, 3'b000} +: 8];
    pp       = amag * digit;
    sh       = W'(pp) << {dig_q, 3'b000};
    neg      = opa[LB-1] ^ opb[LB-1] ^ msub;
    dsub     = (st_q == SeqDivide) | neg;
    addend   = (st_q == SeqDivide) ? W'(prd_q) : sh;
    sum      = acc_q + (dsub ? ~addend : addend) + W'(dsub);
    trial_ok = ~sum[W-1];
    rem_new  = trial_ok ? sum : acc_q;
  end

  // Digit and term bookkeeping.
  logic dig_last, term_last;
  always_comb begin
    unique case (st_q)
      SeqCross: begin
        dig_last  = (dig_q == CrossDigLast);
        term_last = (term_q == CrossTermLast);
      end
      SeqDot: begin
        dig_last  = (dig_q == DotDigLast);
        term_last = (term_q == DotTermLast);
      end
      SeqSquare: begin
        dig_last  = (dig_q == SquareDigLast);
        term_last = (term_q == SquareTermLast);
      end
      default: begin
        dig_last  = 1'b0;
        term_last = 1'b0;
      end
    endcase
  end

  // Square root trial.
  logic [CosBits-1:0]   cand;
  logic [2*CosBits-1:0] csq;
  logic                 fits;
  always_comb begin
    cand = q_q | (CosBits'(1) << bit_q);
    csq  = cand * cand;
    fits = (csq <= (2*CosBits)'(dq_q));
  end

  logic accept, degen_now;
  assign accept    = start && !busy;
  assign degen_now = (l0_q == '0) || (l1_q == '0);

  // Next state.
  always_comb begin
    st_d = st_q;
    unique case (st_q)
      SeqCollect: if (start && vcnt_q == 3'd7) st_d = SeqLoadP0;
      SeqLoadP0:  st_d = SeqLoadP1;
      SeqLoadP1:  st_d = SeqLoadP2;
      SeqLoadP2:  st_d = SeqCross;
      SeqCross:   if (dig_last && term_last) st_d = face_q ? SeqDot : SeqLoadP0;
      SeqDot:     if (dig_last && term_last) st_d = SeqCheck;
      SeqCheck:   st_d = degen_now ? SeqEmit : SeqSquare;
      SeqSquare:  if (dig_last && term_last) st_d = SeqDivide;
      SeqDivide:  if (bit_q == '0) st_d = SeqRoot;
      SeqRoot:    if (bit_q == '0) st_d = SeqEmit;
      SeqEmit:    st_d = (edge_q == EdgeLast) ? SeqCollect : SeqLoadP0;
      default:    st_d = SeqCollect;
    endcase
  end

  // Outputs.
  always_comb begin
    busy               = (st_q != SeqCollect);
    res_strobe_o       = (st_q == SeqEmit);
    res_o.edge_index   = edge_q;
    res_o.cosine       = q_q;
    res_o.degenerate   = degen_q;
    res_o.last_edge    = (edge_q == EdgeLast);
  end

  // Control registers.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      st_q   <= SeqCollect;
      vcnt_q <= '0;
      edge_q <= '0;
      face_q <= 1'b0;
      term_q <= '0;
      dig_q  <= '0;
      bit_q  <= '0;
    end else begin
      st_q <= st_d;
      if (accept) begin
        vcnt_q <= vcnt_q + 3'd1;
        edge_q <= '0;
        face_q <= 1'b0;
      end
      if (st_q == SeqCross || st_q == SeqDot || st_q == SeqSquare) begin
        if (dig_last) begin
          dig_q  <= '0;
          term_q <= term_last ? 4'd0 : term_q + 4'd1;
        end else begin
          dig_q <= dig_q + 1'b1;
        end
      end else begin
        dig_q  <= '0;
        term_q <= '0;
      end
      // Flip face after each normal: face 1 next, then back to 0 for the dots.
      if (st_q == SeqCross && dig_last && term_last) face_q <= ~face_q;
      if (st_q == SeqSquare && dig_last && term_last) bit_q <= BW'(2 * CosFracBits);
      if (st_q == SeqDivide) bit_q <= (bit_q == '0) ? BW'(CosFracBits) : bit_q - 1'b1;
      if (st_q == SeqRoot) bit_q <= bit_q - 1'b1;
      if (st_q == SeqEmit) edge_q <= edge_q + 1'b1;
    end
  end

  // Datapath registers.
  always_ff @(posedge clk_i) begin
    if (accept) begin
      vert_q[vcnt_q][0] <= CB'($unsigned(in_i.coord_x));
      vert_q[vcnt_q][1] <= CB'($unsigned(in_i.coord_y));
      vert_q[vcnt_q][2] <= CB'($unsigned(in_i.coord_z));
    end
    unique case (st_q)
      SeqLoadP0: begin
        for (int k = 0; k < 3; k++) p0_q[k] <= vert_q[vidx][k];
        acc_q <= '0;
      end
      SeqLoadP1: for (int k = 0; k < 3; k++) a_q[k] <= DB'(vert_q[vidx][k]) - DB'(p0_q[k]);
      SeqLoadP2: for (int k = 0; k < 3; k++) b_q[k] <= DB'(vert_q[vidx][k]) - DB'(p0_q[k]);
      SeqCross: begin
        if (dig_last && term_q[0]) begin
          if (face_q) n1_q[term_q[2:1]] <= sum[NB-1:0];
          else        n0_q[term_q[2:1]] <= sum[NB-1:0];
          acc_q <= '0;
        end else begin
          acc_q <= sum;
        end
      end
      SeqDot: begin
        if (dig_last && (term_q == 4'd2 || term_q == 4'd5 || term_q == 4'd8)) begin
          acc_q <= '0;
        end else begin
          acc_q <= sum;
        end
        if (dig_last) begin
          priority case (term_q)
            4'd2: dp_q <= sum[LB-1:0];
            4'd5: l0_q <= sum[LB-1:0];
            4'd8: l1_q <= sum[LB-1:0];
            default: ;
          endcase
        end
      end
      SeqCheck: begin
        degen_q <= degen_now;
        q_q     <= '0;
        acc_q   <= '0;
      end
      SeqSquare: begin
        // Hold L0*L1 as divisor; |dp|^2 stays in the accumulator as dividend.
        if (dig_last && term_q == 4'd0) begin
          prd_q <= sum[PW-1:0];
          acc_q <= '0;
        end else begin
          acc_q <= sum;
        end
      end
      SeqDivide: begin
        acc_q <= rem_new << 1;
        dq_q  <= {dq_q[QW-2:0], trial_ok};
      end
      SeqRoot: if (fits) q_q <= cand;
      default: ;
    endcase
  end

`ifndef NO_ASSERTIONS
  a_strobe_busy: assert property (@(posedge clk_i) disable iff (!rst_ni)
    res_strobe_o |-> busy) else $error("result strobe while idle");
  a_last_idle: assert property (@(posedge clk_i) disable iff (!rst_ni)
    res_strobe_o && res_o.last_edge |=> !busy) else $error("busy after last edge");
  a_degen_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    res_strobe_o && res_o.degenerate |-> res_o.cosine == '0)
    else $error("degenerate edge with nonzero cosine");
  a_cos_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    res_strobe_o |-> res_o.cosine <= (CosBits'(1) << CosFracBits))
    else $error("cosine above one");
  a_eighth_busy: assert property (@(posedge clk_i) disable iff (!rst_ni)
    accept && vcnt_q == 3'd7 |=> busy && edge_q == '0)
    else $error("eighth vertex did not start edge pass");
`endif

endmodule

// ----- sim/hex_dihedral_cosines_test.sv -----
// ----------------------------------------------------------------------------
// hex_dihedral_cosines_test: self-checking bench for the hex dihedral cosines
// Feeds hex elements vertex by vertex and checks each edge cosine item against
// an exact wide-integer model of the dihedral cosine or typed-in expectations.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module hex_dihedral_cosines_test;
  import hdc_pkg::*;

  localparam int  NumDirected = 24;
  localparam int  NumElements = 40;          // random elements, 8 items each
  localparam int  SettleCycles = 2500;       // idle time after the queue drains
  localparam longint CycleLimit = 3000000;

  logic       clk_i = 1'b0;
  logic       rst_ni = 1'b0;
  logic       start = 1'b0;
  logic       busy;
  in_item_t   in_i = '0;
  logic       res_strobe_o;
  out_item_t  res_o;

  hex_dihedral_cosines dut (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .start       (start),
    .busy        (busy),
    .in_i        (in_i),
    .res_strobe_o(res_strobe_o),
    .res_o       (res_o)
  );

  always begin
    #1 clk_i = 1'b1;
    #1 clk_i = 1'b0;
  end

  // First three corners {v0, v1, v2} of the two faces that meet at each edge.
  int unsigned face_tri [NumEdges][2][3] = '{
    '{'{1,0,4}, '{0,1,2}}, '{'{2,1,5}, '{1,2,3}}, '{'{3,2,6}, '{2,3,0}},
    '{'{0,3,7}, '{3,0,1}}, '{'{5,4,7}, '{4,5,1}}, '{'{6,5,4}, '{5,6,2}},
    '{'{7,6,5}, '{6,7,3}}, '{'{4,7,6}, '{7,4,0}}, '{'{0,4,5}, '{0,3,7}},
    '{'{1,5,6}, '{1,0,4}}, '{'{2,6,7}, '{2,1,5}}, '{'{3,7,4}, '{3,2,6}}
  };

  // Model state: the corners collected so far for the current element.
  longint    corner [NumVerts][3];
  int        corner_count = 0;

  out_item_t pending_cosines [$];
  int        mismatches = 0;
  int        checked = 0;
  int        degenerate_seen = 0;
  longint    cycles = 0;

  // Directed rows: expected values are typed in only for elements whose
  // cosines are obvious (all degenerate, or a box with right-angle edges).
  typedef struct {
    in_item_t   vtx;
    bit         typed;
    logic [16:0] cos_val;
    bit         deg_val;
  } row_t;
  row_t directed [NumDirected];

  function automatic void face_normal(input int e, input int f, output longint n[3]);
    longint a[3], b[3];
    for (int k = 0; k < 3; k++) begin
      a[k] = corner[face_tri[e][f][1]][k] - corner[face_tri[e][f][0]][k];
      b[k] = corner[face_tri[e][f][2]][k] - corner[face_tri[e][f][0]][k];
    end
    n[0] = a[1] * b[2] - a[2] * b[1];
    n[1] = a[2] * b[0] - a[0] * b[2];
    n[2] = a[0] * b[1] - a[1] * b[0];
  endfunction

  function automatic logic signed [127:0] dot3(input longint p[3], input longint r[3]);
    logic signed [127:0] acc, x, y;
    acc = '0;
    for (int k = 0; k < 3; k++) begin
      x = p[k];
      y = r[k];
      acc += x * y;
    end
    return acc;
  endfunction

  // Exact truncated cosine: largest q with q^2*L0*L1 <= dp^2 * 2^32, capped at 1.0.
  function automatic out_item_t edge_cosine(input int e);
    out_item_t r;
    longint n0[3], n1[3];
    logic signed [127:0] dp, l0, l1;
    logic [255:0] prod, rhs, cand, lhs, q;
    face_normal(e, 0, n0);
    face_normal(e, 1, n1);
    dp = dot3(n0, n1);
    l0 = dot3(n0, n0);
    l1 = dot3(n1, n1);
    r.edge_index = EdgeBits'(e);
    r.last_edge  = (e == NumEdges - 1);
    r.degenerate = (l0 == 0) || (l1 == 0);
    r.cosine     = '0;
    if (!r.degenerate) begin
      if (dp < 0) dp = -dp;
      prod = 256'(l0) * 256'(l1);
      rhs  = (256'(dp) * 256'(dp)) << (2 * CosFracBits);
      q    = '0;
      for (int bitpos = CosFracBits; bitpos >= 0; bitpos--) begin
        cand = q | (256'(1) << bitpos);
        lhs  = cand * cand * prod;
        if (lhs <= rhs) q = cand;
      end
      if (q > (256'(1) << CosFracBits)) q = 256'(1) << CosFracBits;
      r.cosine = CosBits'(q);
    end
    return r;
  endfunction

  // Store one accepted vertex; when the element's last corner is in, queue an expected cosine for every edge.
  function automatic void take_vertex(input in_item_t v, input bit typed,
                                      input logic [16:0] cos_val, input bit deg_val);
    out_item_t r;
    corner[corner_count][0] = longint'(v.coord_x);
    corner[corner_count][1] = longint'(v.coord_y);
    corner[corner_count][2] = longint'(v.coord_z);
    if (corner_count == NumVerts - 1) begin
      for (int e = 0; e < NumEdges; e++) begin
        if (typed) begin
          r.edge_index = EdgeBits'(e);
          r.cosine     = cos_val;
          r.degenerate = deg_val;
          r.last_edge  = (e == NumEdges - 1);
        end else begin
          r = edge_cosine(e);
        end
        pending_cosines.push_back(r);
      end
    end
    corner_count = (corner_count + 1) % NumVerts;
  endfunction

  // Hold the vertex until the block takes it, then idle for a random gap that may be zero.
  task automatic send_vertex(input in_item_t v, input bit typed,
                             input logic [16:0] cos_val, input bit deg_val);
    int gap;
    @(negedge clk_i);
    start = 1'b1;
    in_i  = v;
    do @(posedge clk_i); while (busy);
    take_vertex(v, typed, cos_val, deg_val);
    gap = ($urandom_range(0, 9) < 7) ? $urandom_range(0, 3) : $urandom_range(4, 60);
    if ($urandom_range(0, 3) == 0) gap = 0;
    if (gap > 0) begin
      @(negedge clk_i);
      start = 1'b0;
      in_i  = in_item_t'(48'({$urandom, $urandom}));
      repeat (gap - 1) @(negedge clk_i);
    end
  endtask

  function automatic in_item_t mk(input int x, input int y, input int z);
    in_item_t v;
    v.coord_x = 16'(x);
    v.coord_y = 16'(y);
    v.coord_z = 16'(z);
    return v;
  endfunction

  // Check each cosine item against the oldest expectation.
  always @(posedge clk_i) begin
    if (rst_ni && res_strobe_o) begin
      if (pending_cosines.size() == 0) begin
        mismatches++;
        if (mismatches <= 10) $display("unexpected cosine item %p", res_o);
      end else begin
        out_item_t want;
        want = pending_cosines.pop_front();
        checked++;
        if (res_o.degenerate) degenerate_seen++;
        if (res_o !== want) begin
          mismatches++;
          if (mismatches <= 10)
            $display("edge %0d: expected cos=%0d deg=%0b last=%0b, got edge=%0d cos=%0d deg=%0b last=%0b",
                     want.edge_index, want.cosine, want.degenerate, want.last_edge,
                     res_o.edge_index, res_o.cosine, res_o.degenerate, res_o.last_edge);
        end
      end
    end
  end

  // Watchdog: end the run if the block hangs.
  always @(posedge clk_i) begin
    cycles++;
    if (cycles > CycleLimit) begin
      $display("timeout after %0d cycles", cycles);
      $display("[FAIL] regression broken");
      $finish;
    end
  end

  initial begin
    int mode, span;
    in_item_t v;

    // Element 1: all corners at the origin, every normal collapses.
    for (int i = 0; i < 8; i++) directed[i] = '{mk(0, 0, 0), 1'b1, 17'd0, 1'b1};
    // Element 2: box spanning the full coordinate range, all edges right angles.
    for (int i = 0; i < 8; i++) begin
      int x, y, z;
      x = (i == 1 || i == 2 || i == 5 || i == 6) ? 32767 : -32768;
      y = (i == 2 || i == 3 || i == 6 || i == 7) ? 32767 : -32768;
      z = (i >= 4) ? 32767 : -32768;
      directed[8 + i] = '{mk(x, y, z), 1'b1, 17'd0, 1'b0};
    end
    // Element 3: sheared box with one corner pulled onto another (mixed edges).
    directed[16] = '{mk(0, 0, 0), 1'b0, 17'd0, 1'b0};
    directed[17] = '{mk(100, 0, 0), 1'b0, 17'd0, 1'b0};
    directed[18] = '{mk(130, 90, 0), 1'b0, 17'd0, 1'b0};
    directed[19] = '{mk(0, 100, 0), 1'b0, 17'd0, 1'b0};
    directed[20] = '{mk(0, 0, 0), 1'b0, 17'd0, 1'b0};
    directed[21] = '{mk(100, -5, 100), 1'b0, 17'd0, 1'b0};
    directed[22] = '{mk(-32768, 32767, -1), 1'b0, 17'd0, 1'b0};
    directed[23] = '{mk(-3, 100, 100), 1'b0, 17'd0, 1'b0};

    repeat (5) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni = 1'b1;

    for (int i = 0; i < NumDirected; i++)
      send_vertex(directed[i].vtx, directed[i].typed, directed[i].cos_val,
                  directed[i].deg_val);

    // Random elements: mostly near-box shapes with jitter, some full-range
    // noise, some with collapsed corners to drive degenerate faces.
    for (int el = 0; el < NumElements; el++) begin
      if (el == NumElements / 2) begin
        // Drain completely once before carrying on.
        wait (pending_cosines.size() == 0);
      end
      mode = $urandom_range(0, 9);
      span = (1 << $urandom_range(2, 14));
      for (int i = 0; i < 8; i++) begin
        if (mode < 2) begin
          v = in_item_t'(48'({$urandom, $urandom}));
        end else if (mode < 4 && $urandom_range(0, 1) == 1) begin
          v = mk(7, -7, 7);
        end else begin
          int x, y, z;
          x = ((i == 1 || i == 2 || i == 5 || i == 6) ? span : -span)
              + $urandom_range(0, span) - span / 2;
          y = ((i == 2 || i == 3 || i == 6 || i == 7) ? span : -span)
              + $urandom_range(0, span) - span / 2;
          z = ((i >= 4) ? span : -span) + $urandom_range(0, span) - span / 2;
          v = mk(x, y, z);
        end
        send_vertex(v, 1'b0, 17'd0, 1'b0);
      end
    end
    @(negedge clk_i);
    start = 1'b0;

    wait (pending_cosines.size() == 0);
    repeat (SettleCycles) @(posedge clk_i);

    $display("checked %0d edge cosines from %0d elements, %0d of them degenerate",
             checked, NumDirected / 8 + NumElements, degenerate_seen);
    if (mismatches == 0 && pending_cosines.size() == 0) begin
      $display("[ OK ] regression clean");
    end else begin
      $display("%0d mismatches, %0d cosines still pending", mismatches,
               pending_cosines.size());
      $display("[FAIL] regression broken");
    end
    $finish;
  end

endmodule

// ----- hex_dihedral_cosines.f -----
hdl/hdc_pkg.sv
hdl/hex_dihedral_cosines.sv
sim/hex_dihedral_cosines_test.sv
